// ----- src/rvnp_pkg.sv -----
`timescale 1ns / 1ps
package rvnp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_DOT,
    ST_AXIS,
    ST_OUT
  } state_t;

  localparam logic MODE_RAY = 1'b0;
  localparam logic MODE_VOL = 1'b1;

  localparam int CODE_W  = 4;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 31;
  localparam int BEST_W  = 32;

  localparam logic [BEST_W-1:0] BEST_NONE = '1;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

endpackage

// ----- src/rvnp_in_if.sv -----
`timescale 1ns / 1ps
interface rvnp_in_if import rvnp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] span_x;
  logic signed [COORD_WIDTH-1:0] span_y;
  logic signed [COORD_WIDTH-1:0] span_z;
  logic                          hoverable;
  logic [CODE_W-1:0]             region_code;
  logic [INDEX_W-1:0]            region_index;
  logic                          last_volume;

  modport source (
    output valid, mode, point_x, point_y, point_z, span_x, span_y, span_z,
           hoverable, region_code, region_index, last_volume,
    input  ready
  );
  modport sink (
    input  valid, mode, point_x, point_y, point_z, span_x, span_y, span_z,
           hoverable, region_code, region_index, last_volume,
    output ready
  );
endinterface

// ----- src/rvnp_out_if.sv -----
`timescale 1ns / 1ps
interface rvnp_out_if import rvnp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hovered;
  logic [CODE_W-1:0]  hit_region_code;
  logic [INDEX_W-1:0] hit_region_index;
  logic [DIST_W-1:0]  hit_distance;

  modport source (
    output valid, hovered, hit_region_code, hit_region_index, hit_distance,
    input  ready
  );
  modport sink (
    input  valid, hovered, hit_region_code, hit_region_index, hit_distance,
    output ready
  );
endinterface

// ----- src/ray_volume_nearest_pick_unit.sv -----
`timescale 1ns / 1ps
// Ray item: squares of the span on the shared multiplier, an integer root, then three
//   divides for the unit direction. No result.
// Volume item: dot product, then axis tests, on the shared multiplier;
//   non-hoverable volumes skip both, a negative projection skips the axis tests.
//   A last volume then holds its result until taken.
// One item at a time; ready only while idle.
// Reset (rst, synchronous): zero ray, best hit cleared, block idle.
module ray_volume_nearest_pick_unit import rvnp_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  rvnp_in_if.sink    query,
  rvnp_out_if.source pick
);
  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 2;
  localparam int AW   = W + 3;
  localparam int BW   = (W + 1 > UW) ? W + 1 : UW;
  localparam int PW   = AW + BW;
  localparam int ACCW = PW + 2;
  localparam int DW   = PW + 1;
  localparam int PRW  = (AW > BEST_W) ? AW : BEST_W;

  state_t state, state_next;
  logic [1:0] cnt;

  logic signed [W-1:0]  origin [3];
  logic signed [W-1:0]  span   [3];
  logic signed [W:0]    tvec   [3];
  logic signed [UW-1:0] unit   [3];
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] acc_sum;
  logic signed [AW-1:0] proj;
  logic [CODE_W-1:0]    code;
  logic [INDEX_W-1:0]   index;
  logic                 last_v;
  logic                 inside_all;

  logic [BEST_W-1:0]  best_dist;
  logic [CODE_W-1:0]  best_code;
  logic [INDEX_W-1:0] best_index;
  logic               any_hit;

  logic [1:0] op_idx, prev_idx;
  logic [W-1:0] mag_sel;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic           sq_start, sq_done;
  logic [W-1:0]   sq_root;
  logic           dv_start, dv_done;
  logic [1:0]     dv_idx;
  logic [W-1:0]   dv_num;
  logic [F:0]     dv_quo;

  logic signed [PW-1:0] floored;
  logic signed [DW-1:0] delta, half_ext;
  logic                 axis_ok;
  logic [PRW-1:0]       proj_ext;
  logic [DIST_W-1:0]    dist_sat;
  logic                 accept;

  assign accept   = query.valid && query.ready;
  assign op_idx   = (cnt == 2'd3) ? 2'd0 : cnt;
  assign prev_idx = cnt - 2'd1;
  assign mag_sel  = span[op_idx][W-1] ? W'(-span[op_idx]) : W'(span[op_idx]);
  assign acc_sum  = acc + ACCW'(prod);

  always_comb begin
    unique case (state)
      ST_SQ: begin
        mul_a = signed'(AW'(mag_sel));
        mul_b = signed'(BW'(mag_sel));
      end
      ST_AXIS: begin
        mul_a = proj;
        mul_b = BW'(unit[op_idx]);
      end
      default: begin
        mul_a = AW'(tvec[op_idx]);
        mul_b = BW'(unit[op_idx]);
      end
    endcase
  end

  rvnp_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  rvnp_isqrt #(.W(W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc_sum[2*W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign dv_idx = (state == ST_ROOT) ? 2'd0 : cnt + 2'd1;
  assign dv_num = span[dv_idx][W-1] ? W'(-span[dv_idx]) : W'(span[dv_idx]);

  rvnp_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (sq_root),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // axis test for the product that comes back this cycle
  assign floored  = prod >>> F;
  assign delta    = DW'(floored) - DW'(tvec[prev_idx]);
  assign half_ext = DW'(span[prev_idx]);
  assign axis_ok  = (delta <= half_ext) && (delta >= -half_ext);
  assign proj_ext = PRW'(unsigned'(proj));
  assign dist_sat = (proj_ext > PRW'(DIST_MAX)) ? DIST_MAX : proj_ext[DIST_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (query.mode == MODE_RAY) begin
            state_next = ST_SQ;
          end else if (query.hoverable) begin
            state_next = ST_DOT;
          end else if (query.last_volume) begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SQ:   if (cnt == 2'd3) state_next = ST_ROOT;
      ST_ROOT: if (sq_done) state_next = ST_DIV;
      ST_DIV:  if (dv_done && cnt == 2'd2) state_next = ST_IDLE;
      ST_DOT: begin
        if (cnt == 2'd3) begin
          if (acc_sum >= 0) state_next = ST_AXIS;
          else state_next = last_v ? ST_OUT : ST_IDLE;
        end
      end
      ST_AXIS: if (cnt == 2'd3) state_next = last_v ? ST_OUT : ST_IDLE;
      ST_OUT:  if (pick.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    query.ready = (state == ST_IDLE);
    pick.valid  = (state == ST_OUT);
    sq_start    = (state == ST_SQ) && (cnt == 2'd3);
    dv_start    = ((state == ST_ROOT) && sq_done) ||
                  ((state == ST_DIV) && dv_done && (cnt != 2'd2));
  end

  assign pick.hovered          = any_hit;
  assign pick.hit_region_code  = any_hit ? best_code : '0;
  assign pick.hit_region_index = any_hit ? best_index : '0;
  assign pick.hit_distance     = any_hit ? best_dist[DIST_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      best_dist  <= BEST_NONE;
      best_code  <= '0;
      best_index <= '0;
      any_hit    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        unit[i]   <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          acc <= '0;
          if (accept) begin
            span[0] <= query.span_x;
            span[1] <= query.span_y;
            span[2] <= query.span_z;
            if (query.mode == MODE_RAY) begin
              origin[0]  <= query.point_x;
              origin[1]  <= query.point_y;
              origin[2]  <= query.point_z;
              best_dist  <= BEST_NONE;
              best_code  <= '0;
              best_index <= '0;
              any_hit    <= 1'b0;
            end else begin
              tvec[0] <= (W+1)'(query.point_x) - (W+1)'(origin[0]);
              tvec[1] <= (W+1)'(query.point_y) - (W+1)'(origin[1]);
              tvec[2] <= (W+1)'(query.point_z) - (W+1)'(origin[2]);
              code    <= query.region_code;
              index   <= query.region_index;
              last_v  <= query.last_volume;
            end
          end
        end
        ST_SQ, ST_DOT: begin
          cnt <= cnt + 2'd1;
          if (cnt != 2'd0) acc <= acc_sum;
          if (state == ST_DOT && cnt == 2'd3) begin
            proj       <= AW'(acc_sum >>> F);
            inside_all <= 1'b1;
            cnt        <= '0;
          end
          if (state == ST_SQ && cnt == 2'd3) cnt <= '0;
        end
        ST_ROOT: cnt <= '0;
        ST_DIV: begin
          if (dv_done) begin
            if (sq_root == '0) unit[cnt] <= '0;
            else if (span[cnt][W-1]) unit[cnt] <= -signed'(UW'(dv_quo));
            else unit[cnt] <= signed'(UW'(dv_quo));
            cnt <= cnt + 2'd1;
          end
        end
        ST_AXIS: begin
          cnt <= cnt + 2'd1;
          if (cnt != 2'd0) inside_all <= inside_all && axis_ok;
          if (cnt == 2'd3 && inside_all && axis_ok &&
              {1'b0, dist_sat} < best_dist) begin
            best_dist  <= {1'b0, dist_sat};
            best_code  <= code;
            best_index <= index;
            any_hit    <= 1'b1;
          end
        end
        ST_OUT: begin
          if (pick.ready) begin
            best_dist  <= BEST_NONE;
            best_code  <= '0;
            best_index <= '0;
            any_hit    <= 1'b0;
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(query.ready && pick.valid))
    else $error("input ready while a result is pending");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && pick.ready) |=> (!any_hit && best_dist == BEST_NONE))
    else $error("best hit not cleared after result");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> !best_dist[BEST_W-1])
    else $error("hit distance not saturated");

  a_ray_clears: assert property (@(posedge clk) disable iff (rst)
    (query.valid && query.ready && query.mode == MODE_RAY) |=> !any_hit)
    else $error("ray item did not clear best hit");
endmodule

// ----- src/rvnp_mul.sv -----
`timescale 1ns / 1ps
module rvnp_mul #(
  parameter int AW = 35,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ----- src/rvnp_isqrt.sv -----
`timescale 1ns / 1ps
module rvnp_isqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);
  localparam int CW = $clog2(W + 1);
  localparam logic [2*W-1:0] BIT0 = {2'b01, {(2*W-2){1'b0}}};

  logic [2*W-1:0] x;
  logic [2*W-1:0] res;
  logic [2*W-1:0] bitv;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [2*W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        res  <= '0;
        bitv <= BIT0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/rvnp_div.sv -----
`timescale 1ns / 1ps
// (num << F) / den, restoring, for num <= den: quotient fits F+1 bits
module rvnp_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [F:0]   quo
);
  localparam int CW = $clog2(F + 1);

  logic [W:0]    rem;
  logic          nb;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem[W-1:0], nb};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {2'b00, num[W-1:1]};
        nb   <= num[0];
        quo  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? trial - {1'b0, den} : trial;
        quo  <= {quo[F-1:0], ge};
        nb   <= 1'b0;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(F)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- bench/ray_volume_nearest_pick_unit_tb.sv -----
`timescale 1ns / 1ps
module ray_volume_nearest_pick_unit_tb;
  import rvnp_pkg::*;

  localparam int  CW       = 32;
  localparam int  FB       = 16;
  localparam int  LIMIT    = 2000000;
  localparam int  N_RANDOM = 930;
  localparam int  DRAIN    = 300;

  typedef struct {
    logic                 mode;
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] sx, sy, sz;
    logic                 hoverable;
    logic [CODE_W-1:0]    code;
    logic [INDEX_W-1:0]   index;
    logic                 last;
  } pick_item_t;

  typedef struct {
    logic               hovered;
    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } pick_result_t;

  class pick_scoreboard;
    longint       ux, uy, uz, ox, oy, oz;
    logic [31:0]  best_dist;
    logic [3:0]   best_code;
    logic [7:0]   best_index;
    bit           any_hit;
    pick_result_t pending[$];
    int           errors;

    function new();
      ux = 0; uy = 0; uz = 0; ox = 0; oy = 0; oz = 0;
      errors = 0;
      clear_best();
    endfunction

    function void clear_best();
      best_dist = '1;
      best_code = '0;
      best_index = '0;
      any_hit = 0;
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint normalize(longint d, longint unsigned len);
      longint unsigned q;
      if (len == 0) return 0;
      q = (magnitude(d) << FB) / len;
      return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    // |floor(unit*proj) - to_c| against the half extent
    function bit on_axis(longint unit, longint proj, longint to_c, longint half);
      longint delta;
      delta = ((unit * proj) >>> FB) - to_c;
      return longint'(magnitude(delta)) <= half && delta >= -half;
    endfunction

    function void note_input(pick_item_t it);
      longint px, py, pz, sx, sy, sz, tx, ty, tz, dot, proj;
      longint unsigned len;
      logic [31:0] d;
      pick_result_t r;
      px = it.px; py = it.py; pz = it.pz;
      sx = it.sx; sy = it.sy; sz = it.sz;
      if (it.mode == MODE_RAY) begin
        len = root64(magnitude(sx) * magnitude(sx) + magnitude(sy) * magnitude(sy)
                     + magnitude(sz) * magnitude(sz));
        ox = px; oy = py; oz = pz;
        ux = normalize(sx, len);
        uy = normalize(sy, len);
        uz = normalize(sz, len);
        clear_best();
        return;
      end
      if (it.hoverable) begin
        tx = px - ox; ty = py - oy; tz = pz - oz;
        dot = tx * ux + ty * uy + tz * uz;
        if (dot >= 0) begin
          proj = dot >>> FB;
          if (on_axis(ux, proj, tx, sx) && on_axis(uy, proj, ty, sy) &&
              on_axis(uz, proj, tz, sz)) begin
            d = proj > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : proj[31:0];
            if (d < best_dist) begin
              best_dist = d;
              best_code = it.code;
              best_index = it.index;
              any_hit = 1;
            end
          end
        end
      end
      if (it.last) begin
        r.hovered = any_hit;
        r.code = any_hit ? best_code : '0;
        r.index = any_hit ? best_index : '0;
        r.distance = any_hit ? best_dist[DIST_W-1:0] : '0;
        pending.insert(pending.size(), r);
        clear_best();
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(pick_result_t got);
      pick_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result, hovered", got.hovered, 0);
        return;
      end
      want = pending.pop_front();
      if (got.hovered !== want.hovered) report("hovered", got.hovered, want.hovered);
      if (got.code !== want.code) report("hit_region_code", got.code, want.code);
      if (got.index !== want.index) report("hit_region_index", got.index, want.index);
      if (got.distance !== want.distance)
        report("hit_distance", got.distance, want.distance);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  bit   calm = 0;
  pick_scoreboard sb = new();

  rvnp_in_if #(.COORD_WIDTH(CW)) in_ch ();
  rvnp_out_if out_ch ();

  ray_volume_nearest_pick_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .query(in_ch.sink), .pick(out_ch.source)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, sampled before this edge's updates
  int stall = 0;
  initial out_ch.ready = 0;
  always @(posedge clk) begin
    pick_result_t r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      r.hovered = out_ch.hovered;
      r.code = out_ch.hit_region_code;
      r.index = out_ch.hit_region_index;
      r.distance = out_ch.hit_distance;
      sb.check_result(r);
    end
    if (stall > 0) begin
      out_ch.ready <= 0;
      stall <= stall - 1;
    end else begin
      out_ch.ready <= 1;
      stall <= pick_gap();
    end
  end

  task send(pick_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= it.mode;
    in_ch.point_x <= it.px; in_ch.point_y <= it.py; in_ch.point_z <= it.pz;
    in_ch.span_x <= it.sx; in_ch.span_y <= it.sy; in_ch.span_z <= it.sz;
    in_ch.hoverable <= it.hoverable;
    in_ch.region_code <= it.code;
    in_ch.region_index <= it.index;
    in_ch.last_volume <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  function pick_item_t make(logic mode, longint px, longint py, longint pz,
                            longint sx, longint sy, longint sz,
                            logic hov, int code, int index, logic last);
    pick_item_t it;
    it.mode = mode;
    it.px = CW'(px); it.py = CW'(py); it.pz = CW'(pz);
    it.sx = CW'(sx); it.sy = CW'(sy); it.sz = CW'(sz);
    it.hoverable = hov; it.code = CODE_W'(code); it.index = INDEX_W'(index);
    it.last = last;
    return it;
  endfunction

  function pick_item_t noise();
    return make(1'($urandom_range(0, 1)), int'($urandom), int'($urandom), int'($urandom),
                int'($urandom), int'($urandom), int'($urandom),
                1'($urandom_range(0, 1)), $urandom_range(0, 15),
                $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endfunction

  function longint jitter(int amount);
    return longint'($urandom_range(0, 2 * amount)) - amount;
  endfunction

  function longint half_extent();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return -longint'($urandom_range(1, 1000));
    if (r < 4) return $urandom_range(0, 2000);
    return $urandom_range(0, 1 << 20);
  endfunction

  // volume placed near the current ray so many lists actually hit
  function pick_item_t near_volume(logic last);
    longint t;
    t = $urandom_range(0, 1 << 24);
    if ($urandom_range(0, 9) == 0) t = -t;
    return make(MODE_VOL, sb.ox + ((sb.ux * t) >>> FB) + jitter(1 << 16),
                sb.oy + ((sb.uy * t) >>> FB) + jitter(1 << 16),
                sb.oz + ((sb.uz * t) >>> FB) + jitter(1 << 16),
                half_extent(), half_extent(), half_extent(),
                $urandom_range(0, 9) != 0, $urandom_range(0, 15),
                $urandom_range(0, 255), last);
  endfunction

  initial begin
    longint mx, mn;
    int sent, nvol;
    mx = 64'sh7FFF_FFFF;
    mn = -64'sh8000_0000;
    in_ch.valid = 0; in_ch.mode = 0;
    in_ch.point_x = 0; in_ch.point_y = 0; in_ch.point_z = 0;
    in_ch.span_x = 0; in_ch.span_y = 0; in_ch.span_z = 0;
    in_ch.hoverable = 0; in_ch.region_code = 0; in_ch.region_index = 0;
    in_ch.last_volume = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // volume before any ray: reset ray, tested at the origin
    send(make(MODE_VOL, 0, 0, 0, 0, 0, 0, 1, 3, 7, 1));
    // zero direction ray
    send(make(MODE_RAY, 100, -200, 300, 0, 0, 0, 0, 15, 255, 1));
    send(make(MODE_VOL, 100, -200, 300, 5, 5, 5, 1, 1, 2, 0));
    send(make(MODE_VOL, 200, -200, 300, 5, 5, 5, 1, 4, 9, 1));
    // far hit: saturated distance, tie keeps the first
    send(make(MODE_RAY, mn, 0, 0, mx, 0, 0, 0, 0, 0, 0));
    send(make(MODE_VOL, mx, 0, 0, mx, mx, mx, 1, 15, 255, 0));
    send(make(MODE_VOL, mx, 0, 0, mx, mx, mx, 1, 2, 1, 0));
    // volume at the ray origin, negative half extent, non-hoverable last
    send(make(MODE_VOL, mn, 0, 0, mx, mx, mx, 1, 5, 5, 0));
    send(make(MODE_VOL, 1 << 20, 0, 0, 10, -1, 10, 1, 6, 6, 0));
    send(make(MODE_VOL, 1 << 20, 0, 0, mx, mx, mx, 0, 7, 7, 1));
    // extreme direction, equal hits tie
    send(make(MODE_RAY, mx, mx, mx, mn, mn, mn, 1, 0, 0, 1));
    send(make(MODE_VOL, 0, 0, 0, mx, mx, mx, 1, 8, 8, 0));
    send(make(MODE_VOL, 0, 0, 0, mx, mx, mx, 1, 9, 9, 0));
    send(make(MODE_VOL, mn, mn, mn, 0, 0, 0, 1, 10, 10, 1));
    send(make(MODE_RAY, 0, 0, 0, 1 << 16, 1 << 16, 0, 0, 0, 0, 0));
    send(make(MODE_VOL, 10 << 16, 10 << 16, 0, 1 << 16, 1 << 16, 1 << 16, 1, 11, 12, 0));
    send(make(MODE_VOL, 5 << 16, 5 << 16, 0, 1 << 16, 1 << 16, 1 << 16, 1, 13, 14, 1));
    // next list reuses the ray with a cleared best hit
    send(make(MODE_VOL, 3 << 16, 3 << 16, 1 << 16, 0, 0, 0, 1, 1, 1, 1));

    // hold off until all results are back
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);

    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 6) == 0) begin
        send(noise());
        sent++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send(make(MODE_RAY, jitter(1 << 24), jitter(1 << 24), jitter(1 << 24),
                    jitter(1 << 20), jitter(1 << 20), jitter(1 << 20),
                    1'($urandom_range(0, 1)), $urandom_range(0, 15),
                    $urandom_range(0, 255), 1'($urandom_range(0, 1))));
          sent++;
        end
        nvol = $urandom_range(1, 6);
        for (int i = 0; i < nvol; i++) send(near_volume(i == nvol - 1));
        sent += nvol;
      end
    end
    in_ch.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rvnp_pkg.sv
src/rvnp_in_if.sv
src/rvnp_out_if.sv
src/rvnp_mul.sv
src/rvnp_isqrt.sv
src/rvnp_div.sv
src/ray_volume_nearest_pick_unit.sv
bench/ray_volume_nearest_pick_unit_tb.sv
